FILE: src/misaligned_load_store_unit_assert.svh
// Assertion macros for the misaligned load/store unit.
// Depends on nothing; included by the top level inside its module body.
`ifndef MISALIGNED_LOAD_STORE_UNIT_ASSERT_SVH
`define MISALIGNED_LOAD_STORE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled at the rising clock edge, off during reset.
`define MLSU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mlsu assertion failed");

// Next-cycle implication, sampled at the rising clock edge, off during reset.
`define MLSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mlsu assertion failed");

`endif

FILE: src/mlsu_pkg.sv
// Shared types and constants of the misaligned load/store unit.
// Used by mlsu_decode and misaligned_load_store_unit; depends on nothing.
package mlsu_pkg;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_READ    = 2'd1,
        OP_EMULATE = 2'd2
    } op_t;

    // Instruction length classes (low two bits of the encoding)
    localparam logic [1:0] QUAD_0    = 2'b00;
    localparam logic [1:0] QUAD_2    = 2'b10;
    localparam logic [1:0] QUAD_FULL = 2'b11;

    // 32-bit funct3 codes for loads and stores
    localparam logic [2:0] F3_H  = 3'd1;
    localparam logic [2:0] F3_W  = 3'd2;
    localparam logic [2:0] F3_D  = 3'd3;
    localparam logic [2:0] F3_HU = 3'd5;
    localparam logic [2:0] F3_WU = 3'd6;

    // Compressed funct3 codes
    localparam logic [2:0] C_F3_LW = 3'd2;
    localparam logic [2:0] C_F3_LD = 3'd3;
    localparam logic [2:0] C_F3_SW = 3'd6;
    localparam logic [2:0] C_F3_SD = 3'd7;

    // Access sizes in bytes
    localparam logic [3:0] BYTES_0 = 4'd0;
    localparam logic [3:0] BYTES_2 = 4'd2;
    localparam logic [3:0] BYTES_4 = 4'd4;
    localparam logic [3:0] BYTES_8 = 4'd8;

    typedef struct packed {
        logic       ok;     // encoding recognized
        logic       len4;   // 32-bit instruction
        logic [3:0] bytes;  // access size
        logic       sgn;    // sign-extend load
        logic [4:0] rd;     // load destination
        logic [4:0] src;    // store source
    } dec_t;

    function automatic logic [63:0] size_mask(input logic [3:0] bytes);
        logic [63:0] m;
        begin
            case (bytes)
                BYTES_2: m = 64'h0000_0000_0000_ffff;
                BYTES_4: m = 64'h0000_0000_ffff_ffff;
                default: m = '1;
            endcase
            return m;
        end
    endfunction

endpackage

FILE: src/mlsu_decode.sv
// Decoder of RV64I and RV64C misaligned load/store encodings.
// Depends on mlsu_pkg.
module mlsu_decode (
    input  logic [31:0]      instruction,
    input  logic             store_fault,
    output mlsu_pkg::dec_t   dec
);
    import mlsu_pkg::*;

    logic [2:0] f3_full;
    logic [2:0] f3_c;
    logic [4:0] rp;

    assign f3_full = instruction[14:12];
    assign f3_c    = instruction[15:13];
    assign rp      = {2'b01, instruction[4:2]};

    always_comb
    begin
        dec = '0;
        if (instruction[1:0] == QUAD_FULL)
        begin
            dec.len4 = 1'b1;
            if (store_fault)
            begin
                dec.src = instruction[24:20];
                case (f3_full)
                    F3_H:    begin dec.ok = 1'b1; dec.bytes = BYTES_2; end
                    F3_W:    begin dec.ok = 1'b1; dec.bytes = BYTES_4; end
                    F3_D:    begin dec.ok = 1'b1; dec.bytes = BYTES_8; end
                    default: dec.ok = 1'b0;
                endcase
            end
            else
            begin
                dec.rd = instruction[11:7];
                case (f3_full)
                    F3_H:    begin dec.ok = 1'b1; dec.bytes = BYTES_2; dec.sgn = 1'b1; end
                    F3_W:    begin dec.ok = 1'b1; dec.bytes = BYTES_4; dec.sgn = 1'b1; end
                    F3_D:    begin dec.ok = 1'b1; dec.bytes = BYTES_8; end
                    F3_HU:   begin dec.ok = 1'b1; dec.bytes = BYTES_2; end
                    F3_WU:   begin dec.ok = 1'b1; dec.bytes = BYTES_4; end
                    default: dec.ok = 1'b0;
                endcase
            end
        end
        else if (instruction[1:0] == QUAD_0 || instruction[1:0] == QUAD_2)
        begin
            if (store_fault)
            begin
                dec.src = (instruction[1:0] == QUAD_0) ? rp : instruction[6:2];
                case (f3_c)
                    C_F3_SW: begin dec.ok = 1'b1; dec.bytes = BYTES_4; end
                    C_F3_SD: begin dec.ok = 1'b1; dec.bytes = BYTES_8; end
                    default: dec.ok = 1'b0;
                endcase
            end
            else
            begin
                dec.rd = (instruction[1:0] == QUAD_0) ? rp : instruction[11:7];
                case (f3_c)
                    C_F3_LW: begin dec.ok = 1'b1; dec.bytes = BYTES_4; dec.sgn = 1'b1; end
                    C_F3_LD: begin dec.ok = 1'b1; dec.bytes = BYTES_8; end
                    default: dec.ok = 1'b0;
                endcase
            end
        end
    end

endmodule

FILE: src/misaligned_load_store_unit.sv
// Misaligned load/store emulation unit: top level with the frame register file.
// Depends on mlsu_pkg, mlsu_decode and misaligned_load_store_unit_assert.svh.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one item per transfer: a frame
//   register write, a frame register read, or one faulting access to emulate.
//   Output channel (out_valid/out_ready) carries exactly one result per item,
//   in order of acceptance.
// Flow: an item accepted into the input register is decoded and executed
//   there against the register file; its result is loaded into the output
//   register as stage 1 advances, which a stalled output channel holds back.
// Throughput: one item per cycle while out_ready stays high. The register file
//   write of an item happens at the same edge as its result is registered, so
//   the next item already sees it; decode, byte extension and one register file
//   read are combinational between the input and output registers.
// Reset: all 32 frame registers clear to zero, both stages empty.
// Stall: while out_ready is low the output register holds its result; one
//   further item may wait in the input register, after which in_ready drops.
//   Register zero is never written and always reads zero.
module misaligned_load_store_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [4:0]  reg_index,
    input  logic [63:0] reg_value,
    input  logic [31:0] instruction,
    input  logic        store_fault,
    input  logic [63:0] trap_pc,
    input  logic [63:0] fault_addr,
    input  logic [63:0] memory_bytes,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        status,
    output logic [63:0] read_value,
    output logic [63:0] next_pc,
    output logic [63:0] store_addr,
    output logic [63:0] store_data,
    output logic [3:0]  store_byte_count,
    output logic        reg_written,
    output logic [4:0]  dest_reg,
    output logic [63:0] loaded_value
);
    import mlsu_pkg::*;

    // Input register (stage 1)
    logic        s1_valid_reg, s1_valid_next;
    logic [1:0]  op_reg;
    logic [4:0]  reg_index_reg;
    logic [63:0] reg_value_reg;
    logic [31:0] instruction_reg;
    logic        store_fault_reg;
    logic [63:0] trap_pc_reg;
    logic [63:0] fault_addr_reg;
    logic [63:0] memory_bytes_reg;

    // Output register (stage 2)
    logic        out_valid_reg, out_valid_next;
    logic        status_reg, status_next;
    logic [63:0] read_value_reg, read_value_next;
    logic [63:0] next_pc_reg, next_pc_next;
    logic [63:0] store_addr_reg, store_addr_next;
    logic [63:0] store_data_reg, store_data_next;
    logic [3:0]  store_byte_count_reg, store_byte_count_next;
    logic        reg_written_reg, reg_written_next;
    logic [4:0]  dest_reg_reg, dest_reg_next;
    logic [63:0] loaded_value_reg, loaded_value_next;

    // Frame register file
    logic [63:0] frame_reg [32];
    logic        rf_we;
    logic [4:0]  rf_waddr;
    logic [63:0] rf_wdata;
    logic [4:0]  rf_raddr;
    logic [63:0] rf_rdata;

    logic        in_fire;
    logic        s1_advance;
    dec_t        dec;
    logic [63:0] mem_masked;
    logic [63:0] load_ext;

    // Handshake: advance stage 1 whenever the output register is free or drains.
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_fire    = in_valid && in_ready;

    assign s1_valid_next  = in_fire ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_advance ? 1'b1 :
                            ((out_valid_reg && out_ready) ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the input transfer; payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg           <= operation;
            reg_index_reg    <= reg_index;
            reg_value_reg    <= reg_value;
            instruction_reg  <= instruction;
            store_fault_reg  <= store_fault;
            trap_pc_reg      <= trap_pc;
            fault_addr_reg   <= fault_addr;
            memory_bytes_reg <= memory_bytes;
        end
    end

    mlsu_decode u_decode (
        .instruction (instruction_reg),
        .store_fault (store_fault_reg),
        .dec         (dec)
    );

    // One read port: the read operation's index, otherwise the store source.
    assign rf_raddr = (op_reg == OP_READ) ? reg_index_reg : dec.src;
    assign rf_rdata = frame_reg[rf_raddr];

    // Extend the loaded bytes to 64 bits.
    assign mem_masked = memory_bytes_reg & size_mask(dec.bytes);

    always_comb
    begin
        load_ext = mem_masked;
        if (dec.sgn)
        begin
            case (dec.bytes)
                BYTES_2: load_ext = {{48{mem_masked[15]}}, mem_masked[15:0]};
                BYTES_4: load_ext = {{32{mem_masked[31]}}, mem_masked[31:0]};
                default: load_ext = mem_masked;
            endcase
        end
    end

    // Execute the item held in stage 1; every result field defaults to zero.
    always_comb
    begin
        status_next           = 1'b0;
        read_value_next       = '0;
        next_pc_next          = '0;
        store_addr_next       = '0;
        store_data_next       = '0;
        store_byte_count_next = BYTES_0;
        reg_written_next      = 1'b0;
        dest_reg_next         = '0;
        loaded_value_next     = '0;
        rf_we                 = 1'b0;
        rf_waddr              = reg_index_reg;
        rf_wdata              = reg_value_reg;

        case (op_t'(op_reg))
            OP_WRITE:
            begin
                rf_we = (reg_index_reg != 5'd0);
            end
            OP_READ:
            begin
                read_value_next = rf_rdata;
            end
            OP_EMULATE:
            begin
                if (!dec.ok)
                begin
                    status_next  = 1'b1;
                    next_pc_next = trap_pc_reg;
                end
                else
                begin
                    next_pc_next = trap_pc_reg + (dec.len4 ? 64'd4 : 64'd2);
                    if (store_fault_reg)
                    begin
                        store_addr_next       = fault_addr_reg;
                        store_data_next       = rf_rdata & size_mask(dec.bytes);
                        store_byte_count_next = dec.bytes;
                    end
                    else
                    begin
                        reg_written_next  = (dec.rd != 5'd0);
                        dest_reg_next     = dec.rd;
                        loaded_value_next = load_ext;
                        rf_we             = (dec.rd != 5'd0);
                        rf_waddr          = dec.rd;
                        rf_wdata          = load_ext;
                    end
                end
            end
            default:
            begin
                // unused operation code: all-zero result, no state change
            end
        endcase
    end

    // Commit the register file write together with the result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 32; i++)
            begin
                frame_reg[i] <= '0;
            end
        end
        else if (s1_advance && rf_we)
        begin
            frame_reg[rf_waddr] <= rf_wdata;
        end
    end

    // Load the output register as stage 1 advances; hold it while stalled.
    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            status_reg           <= status_next;
            read_value_reg       <= read_value_next;
            next_pc_reg          <= next_pc_next;
            store_addr_reg       <= store_addr_next;
            store_data_reg       <= store_data_next;
            store_byte_count_reg <= store_byte_count_next;
            reg_written_reg      <= reg_written_next;
            dest_reg_reg         <= dest_reg_next;
            loaded_value_reg     <= loaded_value_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign read_value       = read_value_reg;
    assign next_pc          = next_pc_reg;
    assign store_addr       = store_addr_reg;
    assign store_data       = store_data_reg;
    assign store_byte_count = store_byte_count_reg;
    assign reg_written      = reg_written_reg;
    assign dest_reg         = dest_reg_reg;
    assign loaded_value     = loaded_value_reg;

`include "misaligned_load_store_unit_assert.svh"

    // Register zero never changes.
    `MLSU_ASSERT_NOW(a_x0_zero, clk, rst_n, 1'b1, frame_reg[0] == 64'd0)
    // An error result carries no store and no register write.
    `MLSU_ASSERT_NOW(a_err_quiet, clk, rst_n, out_valid_reg && status_reg,
        store_byte_count_reg == BYTES_0 && !reg_written_reg)
    // A reported register write never targets register zero.
    `MLSU_ASSERT_NOW(a_wr_dest, clk, rst_n, out_valid_reg && reg_written_reg,
        dest_reg_reg != 5'd0)
    // A stalled result stays valid and its next pc unchanged.
    `MLSU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid_reg && !out_ready,
        out_valid_reg && $stable(next_pc_reg))
    // A full pipeline behind a stalled receiver takes no new item.
    `MLSU_ASSERT_NOW(a_full_block, clk, rst_n,
        s1_valid_reg && out_valid_reg && !out_ready, !in_ready)

endmodule

FILE: verif/misaligned_load_store_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for misaligned_load_store_unit: directed and random
// register ops and trap emulations with random idling on both channels.
// Depends on mlsu_pkg and the misaligned_load_store_unit RTL.
module misaligned_load_store_unit_tb;
    import mlsu_pkg::*;

    // Operation code the block must treat as a no-op
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // Encodings that no load or store uses
    localparam logic [1:0] QUAD_1    = 2'b01;
    localparam logic [2:0] F3_NONE   = 3'd7;
    localparam logic [2:0] C_F3_NONE = 3'd0;

    localparam int RANDOM_ITEMS = 1625;
    localparam int IDLE_LIMIT   = 2000;  // cycles with no transfer on either side
    localparam int TAIL_CYCLES  = 10;    // extra wait once every outcome has arrived

    typedef struct packed {
        logic        drain_first;   // hold this item until nothing is outstanding
        logic [1:0]  op;
        logic [4:0]  reg_index;
        logic [63:0] reg_value;
        logic [31:0] instruction;
        logic        store_fault;
        logic [63:0] trap_pc;
        logic [63:0] fault_addr;
        logic [63:0] memory_bytes;
    } trap_item_t;

    typedef struct packed {
        logic        status;
        logic [63:0] read_value;
        logic [63:0] next_pc;
        logic [63:0] store_addr;
        logic [63:0] store_data;
        logic [3:0]  store_byte_count;
        logic        reg_written;
        logic [4:0]  dest_reg;
        logic [63:0] loaded_value;
    } lsu_outcome_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  operation = '0;
    logic [4:0]  reg_index = '0;
    logic [63:0] reg_value = '0;
    logic [31:0] instruction = '0;
    logic        store_fault = 1'b0;
    logic [63:0] trap_pc = '0;
    logic [63:0] fault_addr = '0;
    logic [63:0] memory_bytes = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        status;
    logic [63:0] read_value;
    logic [63:0] next_pc;
    logic [63:0] store_addr;
    logic [63:0] store_data;
    logic [3:0]  store_byte_count;
    logic        reg_written;
    logic [4:0]  dest_reg;
    logic [63:0] loaded_value;

    // Items still to send, outcomes still to arrive, and the mirrored frame
    trap_item_t   trap_items[$];
    lsu_outcome_t awaited_outcomes[$];
    logic [63:0]  frame_mirror [32];

    trap_item_t   cur_item;
    lsu_outcome_t seen;
    logic         drain_next = 1'b0;
    logic         snd_calm = 1'b0;
    logic         rsp_calm = 1'b0;
    int unsigned  send_gap = 0;
    int unsigned  rsp_stall = 0;
    int unsigned  idle_cycles = 0;
    int           n_items_total = 0;
    int           n_accepted = 0;
    int           n_checked = 0;
    int           err_count = 0;

    misaligned_load_store_unit u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .operation        (operation),
        .reg_index        (reg_index),
        .reg_value        (reg_value),
        .instruction      (instruction),
        .store_fault      (store_fault),
        .trap_pc          (trap_pc),
        .fault_addr       (fault_addr),
        .memory_bytes     (memory_bytes),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .read_value       (read_value),
        .next_pc          (next_pc),
        .store_addr       (store_addr),
        .store_data       (store_data),
        .store_byte_count (store_byte_count),
        .reg_written      (reg_written),
        .dest_reg         (dest_reg),
        .loaded_value     (loaded_value)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Hold reset, then release it away from the active edge
    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    initial
    begin
        for (int i = 0; i < 32; i++)
            frame_mirror[i] = '0;
    end

    // ------------------------------------------------------------------
    // Predictor: decode the trapped access and update the mirrored frame
    // ------------------------------------------------------------------
    function automatic lsu_outcome_t emulate_trap_item(input trap_item_t it);
        lsu_outcome_t r;
        logic [1:0]   quad;
        logic [2:0]   f3;
        logic         recog;
        logic         sext;
        logic [3:0]   nbytes;
        logic [4:0]   rd;
        logic [4:0]   rs;
        logic [63:0]  keep;
        logic [63:0]  raw;
        logic         sign_bit;
        r = '0;
        recog = 1'b0;
        sext = 1'b0;
        nbytes = BYTES_0;
        rd = '0;
        rs = '0;
        f3 = '0;
        case (it.op)
            OP_WRITE:
            begin
                // x0 is hardwired; drop the write
                if (it.reg_index != 5'd0)
                    frame_mirror[it.reg_index] = it.reg_value;
            end
            OP_READ:
                r.read_value = frame_mirror[it.reg_index];
            OP_EMULATE:
            begin
                quad = it.instruction[1:0];
                if (quad == QUAD_FULL)
                begin
                    // Only funct3 matters; the major opcode is not examined
                    f3 = it.instruction[14:12];
                    if (it.store_fault)
                    begin
                        rs = it.instruction[24:20];
                        case (f3)
                            F3_H: begin recog = 1'b1; nbytes = BYTES_2; end
                            F3_W: begin recog = 1'b1; nbytes = BYTES_4; end
                            F3_D: begin recog = 1'b1; nbytes = BYTES_8; end
                            default: ;
                        endcase
                    end
                    else
                    begin
                        rd = it.instruction[11:7];
                        case (f3)
                            F3_H:  begin recog = 1'b1; nbytes = BYTES_2; sext = 1'b1; end
                            F3_W:  begin recog = 1'b1; nbytes = BYTES_4; sext = 1'b1; end
                            F3_D:  begin recog = 1'b1; nbytes = BYTES_8; end
                            F3_HU: begin recog = 1'b1; nbytes = BYTES_2; end
                            F3_WU: begin recog = 1'b1; nbytes = BYTES_4; end
                            default: ;
                        endcase
                    end
                end
                else if (quad == QUAD_0 || quad == QUAD_2)
                begin
                    // Compressed: quadrant 0 uses x8..x15, quadrant 2 the stack forms
                    f3 = it.instruction[15:13];
                    if (it.store_fault)
                    begin
                        rs = (quad == QUAD_0) ? {2'b01, it.instruction[4:2]}
                                              : it.instruction[6:2];
                        if (f3 == C_F3_SW)
                        begin
                            recog = 1'b1;
                            nbytes = BYTES_4;
                        end
                        else if (f3 == C_F3_SD)
                        begin
                            recog = 1'b1;
                            nbytes = BYTES_8;
                        end
                    end
                    else
                    begin
                        rd = (quad == QUAD_0) ? {2'b01, it.instruction[4:2]}
                                              : it.instruction[11:7];
                        if (f3 == C_F3_LW)
                        begin
                            recog = 1'b1;
                            nbytes = BYTES_4;
                            sext = 1'b1;
                        end
                        else if (f3 == C_F3_LD)
                        begin
                            recog = 1'b1;
                            nbytes = BYTES_8;
                        end
                    end
                end

                if (!recog)
                begin
                    // Unknown encoding: flag it, leave pc where it trapped
                    r.status = 1'b1;
                    r.next_pc = it.trap_pc;
                end
                else
                begin
                    r.next_pc = it.trap_pc + ((quad == QUAD_FULL) ? 64'd4 : 64'd2);
                    if (nbytes == BYTES_2)
                        keep = {48'd0, 16'hffff};
                    else if (nbytes == BYTES_4)
                        keep = {32'd0, 32'hffff_ffff};
                    else
                        keep = {64{1'b1}};
                    if (it.store_fault)
                    begin
                        r.store_addr = it.fault_addr;
                        r.store_data = frame_mirror[rs] & keep;
                        r.store_byte_count = nbytes;
                    end
                    else
                    begin
                        raw = it.memory_bytes & keep;
                        sign_bit = (nbytes == BYTES_2) ? raw[15] : raw[31];
                        if (sext && sign_bit)
                            raw = raw | ~keep;
                        r.loaded_value = raw;
                        r.dest_reg = rd;
                        r.reg_written = (rd != 5'd0);
                        if (rd != 5'd0)
                            frame_mirror[rd] = raw;
                    end
                end
            end
            default: ;  // unused code: no state change, all-zero outcome
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Bias a few pcs toward the top of the address space to exercise wrap
    function automatic logic [63:0] rand_pc();
        if ($urandom_range(0, 15) == 0)
            return {60'hfff_ffff_ffff_ffff, 4'($urandom_range(0, 15))};
        return rand64();
    endfunction

    function automatic logic [31:0] insn32(input logic [2:0] f3, input logic [4:0] rd,
                                           input logic [4:0] rs2);
        logic [31:0] w;
        w = $urandom;
        w[1:0] = QUAD_FULL;
        w[14:12] = f3;
        w[11:7] = rd;
        w[24:20] = rs2;
        return w;
    endfunction

    // Upper halfword stays random: the block must ignore it for compressed forms
    function automatic logic [31:0] insn16(input logic [1:0] q, input logic [2:0] f3,
                                           input logic [4:0] hi_reg, input logic [4:0] lo_reg);
        logic [31:0] w;
        w = $urandom;
        w[1:0] = q;
        w[15:13] = f3;
        w[11:7] = hi_reg;
        w[6:2] = lo_reg;
        return w;
    endfunction

    // Well-formed load or store encoding with random register fields
    function automatic logic [31:0] random_access_insn(input logic st);
        logic [2:0] f3;
        logic [1:0] q;
        int unsigned sel;
        sel = $urandom_range(0, 2);
        if (sel == 0)
        begin
            if (st)
            begin
                case ($urandom_range(0, 2))
                    0: f3 = F3_H;
                    1: f3 = F3_W;
                    default: f3 = F3_D;
                endcase
            end
            else
            begin
                case ($urandom_range(0, 4))
                    0: f3 = F3_H;
                    1: f3 = F3_W;
                    2: f3 = F3_D;
                    3: f3 = F3_HU;
                    default: f3 = F3_WU;
                endcase
            end
            return insn32(f3, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
        end
        q = (sel == 1) ? QUAD_0 : QUAD_2;
        if (st)
            f3 = $urandom_range(0, 1) ? C_F3_SW : C_F3_SD;
        else
            f3 = $urandom_range(0, 1) ? C_F3_LW : C_F3_LD;
        return insn16(q, f3, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
    endfunction

    // Unused fields of each item are randomized so every input bit toggles
    task automatic push_reg(input logic [1:0] op, input logic [4:0] idx,
                            input logic [63:0] val);
        trap_item_t it;
        it.drain_first = drain_next;
        it.op = op;
        it.reg_index = idx;
        it.reg_value = val;
        it.instruction = $urandom;
        it.store_fault = 1'($urandom_range(0, 1));
        it.trap_pc = rand64();
        it.fault_addr = rand64();
        it.memory_bytes = rand64();
        drain_next = 1'b0;
        trap_items.push_back(it);
    endtask

    task automatic push_access(input logic st, input logic [31:0] insn,
                               input logic [63:0] pc, input logic [63:0] mem);
        trap_item_t it;
        it.drain_first = drain_next;
        it.op = OP_EMULATE;
        it.reg_index = 5'($urandom_range(0, 31));
        it.reg_value = rand64();
        it.instruction = insn;
        it.store_fault = st;
        it.trap_pc = pc;
        it.fault_addr = rand64();
        it.memory_bytes = mem;
        drain_next = 1'b0;
        trap_items.push_back(it);
    endtask

    function automatic int unsigned draw_wait(input logic calm);
        return calm ? 0 : $urandom_range(0, 15);
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting
    // ------------------------------------------------------------------
    task automatic report_error(input string msg);
        err_count++;
        if (err_count <= 40)
            $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_error($sformatf("outcome %0d %s: got %h, want %h",
                                   n_checked, name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Driver: present the next item after its drawn gap; predict on transfer
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                awaited_outcomes.push_back(emulate_trap_item(cur_item));
                n_accepted++;
            end
            // Advance only when the channel is free after this edge
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (trap_items.size() != 0 &&
                         (!trap_items[0].drain_first || awaited_outcomes.size() == 0))
                begin
                    cur_item = trap_items.pop_front();
                    in_valid     <= 1'b1;
                    operation    <= cur_item.op;
                    reg_index    <= cur_item.reg_index;
                    reg_value    <= cur_item.reg_value;
                    instruction  <= cur_item.instruction;
                    store_fault  <= cur_item.store_fault;
                    trap_pc      <= cur_item.trap_pc;
                    fault_addr   <= cur_item.fault_addr;
                    memory_bytes <= cur_item.memory_bytes;
                    if ($urandom_range(0, 39) == 0)
                        snd_calm = ~snd_calm;
                    send_gap = draw_wait(snd_calm);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each result transfer with the oldest prediction,
    // then stall out_ready for a drawn number of cycles
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rsp_stall = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                seen.status = status;
                seen.read_value = read_value;
                seen.next_pc = next_pc;
                seen.store_addr = store_addr;
                seen.store_data = store_data;
                seen.store_byte_count = store_byte_count;
                seen.reg_written = reg_written;
                seen.dest_reg = dest_reg;
                seen.loaded_value = loaded_value;
                if (awaited_outcomes.size() == 0)
                begin
                    report_error("result transfer with no outcome outstanding");
                end
                else
                begin
                    lsu_outcome_t want;
                    want = awaited_outcomes.pop_front();
                    check_field("status", 64'(seen.status), 64'(want.status));
                    check_field("read_value", seen.read_value, want.read_value);
                    check_field("next_pc", seen.next_pc, want.next_pc);
                    check_field("store_addr", seen.store_addr, want.store_addr);
                    check_field("store_data", seen.store_data, want.store_data);
                    check_field("store_byte_count", 64'(seen.store_byte_count),
                                64'(want.store_byte_count));
                    check_field("reg_written", 64'(seen.reg_written),
                                64'(want.reg_written));
                    check_field("dest_reg", 64'(seen.dest_reg), 64'(want.dest_reg));
                    check_field("loaded_value", seen.loaded_value, want.loaded_value);
                end
                n_checked++;
                if ($urandom_range(0, 39) == 0)
                    rsp_calm = ~rsp_calm;
                rsp_stall = draw_wait(rsp_calm);
            end
            if (rsp_stall > 0)
            begin
                rsp_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if neither channel moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: directed corners first, then a random mix
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned pick;
        logic        st;

        // Register zero: writes dropped, reads zero
        push_reg(OP_WRITE, 5'd0, {64{1'b1}});
        push_reg(OP_READ, 5'd0, rand64());
        push_reg(OP_WRITE, 5'd31, {64{1'b1}});
        push_reg(OP_WRITE, 5'd9, 64'h8000_0000_8000_8000);
        push_reg(OP_READ, 5'd31, rand64());

        // 32-bit loads, sign and zero extension, one to x0; pc wraps on some
        push_access(1'b0, insn32(F3_H, 5'd5, 5'd0), 64'hffff_ffff_ffff_fffe,
                    64'h1234_5678_9abc_8001);
        push_access(1'b0, insn32(F3_HU, 5'd6, 5'd0), 64'h0, 64'h1234_5678_9abc_8001);
        push_access(1'b0, insn32(F3_W, 5'd7, 5'd0), rand_pc(), 64'h0123_4567_89ab_cdef);
        push_access(1'b0, insn32(F3_WU, 5'd0, 5'd0), rand_pc(), 64'h0123_4567_89ab_cdef);
        push_access(1'b0, insn32(F3_D, 5'd31, 5'd0), {64{1'b1}}, {64{1'b1}});

        // 32-bit stores, one sourced from x0
        push_access(1'b1, insn32(F3_H, 5'd0, 5'd9), rand_pc(), rand64());
        push_access(1'b1, insn32(F3_W, 5'd0, 5'd31), rand_pc(), rand64());
        push_access(1'b1, insn32(F3_D, 5'd0, 5'd0), rand_pc(), rand64());

        // Compressed register-prime and stack-pointer forms
        push_access(1'b0, insn16(QUAD_0, C_F3_LW, 5'd0, 5'd1), rand_pc(), 64'h0000_0000_ffff_fffe);
        push_access(1'b0, insn16(QUAD_0, C_F3_LD, 5'd0, 5'd7), rand_pc(), rand64());
        push_access(1'b1, insn16(QUAD_0, C_F3_SW, 5'd0, 5'd1), rand_pc(), rand64());
        push_access(1'b1, insn16(QUAD_0, C_F3_SD, 5'd0, 5'd7), rand_pc(), rand64());
        push_access(1'b0, insn16(QUAD_2, C_F3_LW, 5'd0, 5'd3), rand_pc(), rand64());
        push_access(1'b0, insn16(QUAD_2, C_F3_LD, 5'd20, 5'd3), {64{1'b1}}, rand64());
        push_access(1'b1, insn16(QUAD_2, C_F3_SW, 5'd4, 5'd20), rand_pc(), rand64());
        push_access(1'b1, insn16(QUAD_2, C_F3_SD, 5'd4, 5'd31), rand_pc(), rand64());

        // Unrecognized encodings and the unused operation code
        push_access(1'b0, insn32(F3_NONE, 5'd3, 5'd3), rand_pc(), rand64());
        push_access(1'b1, insn32(F3_HU, 5'd3, 5'd3), rand_pc(), rand64());
        push_access(1'b0, insn16(QUAD_1, C_F3_LW, 5'd3, 5'd3), rand_pc(), rand64());
        push_access(1'b1, insn16(QUAD_0, C_F3_NONE, 5'd3, 5'd3), rand_pc(), rand64());
        push_reg(OP_UNUSED, 5'd31, rand64());

        // Random mix; drain everything before the first and a middle item
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 0 || n == RANDOM_ITEMS / 2)
                drain_next = 1'b1;
            pick = $urandom_range(0, 99);
            st = 1'($urandom_range(0, 1));
            if (pick < 20)
                push_reg(OP_WRITE, 5'($urandom_range(0, 31)), rand64());
            else if (pick < 30)
                push_reg(OP_READ, 5'($urandom_range(0, 31)), rand64());
            else if (pick < 80)
                push_access(st, random_access_insn(st), rand_pc(), rand64());
            else if (pick < 90)
                push_access(st, $urandom, rand_pc(), rand64());
            else if (pick < 97)
                push_access(~st, random_access_insn(st), rand_pc(), rand64());  // wrong direction
            else
                push_reg(OP_UNUSED, 5'($urandom_range(0, 31)), rand64());
        end
        n_items_total = trap_items.size();

        // Wait until every item is transferred and every outcome has arrived
        while (n_accepted < n_items_total || awaited_outcomes.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (awaited_outcomes.size() != 0)
            report_error($sformatf("%0d outcomes never arrived", awaited_outcomes.size()));

        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: misaligned_load_store_unit.f
+incdir+src
src/mlsu_pkg.sv
src/mlsu_decode.sv
src/misaligned_load_store_unit.sv
verif/misaligned_load_store_unit_tb.sv
